// ===== sv/csi_pkg.sv =====
package csi_pkg;

  typedef enum logic [1:0] {
    PhaseIdle   = 2'd0,
    PhaseStart  = 2'd1,
    PhaseMiddle = 2'd2
  } phase_e;

  typedef struct packed {
    logic signed [31:0] start_y;
    logic signed [31:0] middle_y;
    logic signed [31:0] end_y;
    logic [31:0]        step_width;
    logic               has_term;
    logic               last;
  } job_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  // Rounding bias: half of three units of the Q16.16 result, in Q32.32.
  localparam logic [66:0] RoundBias = 67'd98304;
  // (2^26 - 1) / 3, so that n / 3 = hi * ThirdK + (hi + lo) / 3 with n = hi * 2^26 + lo.
  localparam logic [24:0] ThirdK = 25'd22369621;
  // ceil(2^33 / 3); exact floor division by three for operands below 2^32.
  localparam logic [31:0] ThirdRecip = 32'hAAAAAAAB;

endpackage

// ===== sv/csi_if.sv =====
interface csi_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic               last_sample;

  modport source (output valid, output x_value, output y_value, output last_sample,
                  input ready);
  modport sink (input valid, input x_value, input y_value, input last_sample,
                output ready);
endinterface

interface csi_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] integral;

  modport source (output valid, output integral, input ready);
  modport sink (input valid, input integral, output ready);
endinterface

// ===== sv/csi_front.sv =====
module csi_front
  import csi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  csi_sample_if.sink  sample_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output job_t        push_job_o
);

  phase_e             phase_q, phase_d;
  logic signed [31:0] start_x_q;
  logic signed [31:0] start_y_q;
  logic signed [31:0] middle_y_q;
  logic [31:0]        step_q;
  logic               accept;
  logic signed [32:0] dx;
  logic [32:0]        dx_abs;

  assign sample_i.ready = push_ready_i;
  assign accept = sample_i.valid && sample_i.ready;

  assign dx = 33'(sample_i.x_value) - 33'(start_x_q);
  assign dx_abs = dx[32] ? (33'd0 - dx) : dx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseIdle;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PhaseStart:  phase_d = PhaseMiddle;
        PhaseMiddle: phase_d = PhaseStart;
        default:     phase_d = PhaseStart;
      endcase
      if (sample_i.last_sample) begin
        phase_d = PhaseIdle;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (phase_q == PhaseStart) begin
        step_q     <= dx_abs[31:0];
        middle_y_q <= sample_i.y_value;
      end else begin
        start_x_q <= sample_i.x_value;
        start_y_q <= sample_i.y_value;
      end
    end
  end

  assign push_valid_o = accept && ((phase_q == PhaseMiddle) || sample_i.last_sample);

  always_comb begin
    push_job_o.start_y    = start_y_q;
    push_job_o.middle_y   = middle_y_q;
    push_job_o.end_y      = sample_i.y_value;
    push_job_o.step_width = step_q;
    push_job_o.has_term   = (phase_q == PhaseMiddle);
    push_job_o.last       = sample_i.last_sample;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sample_i.last_sample) |=> (phase_q == PhaseIdle))
    else $error("front phase not cleared after the last sample of a set");

endmodule

// ===== sv/csi_fifo.sv =====
module csi_fifo
  import csi_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_job_o
);

  localparam logic [QueueCntW-1:0] CountFull = QueueCntW'(QueueDepth);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q;
  logic [QueuePtrW-1:0] rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push;
  logic                 pop;

  assign push_ready_o = (count_q != CountFull);
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("queue count exceeds its depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// ===== sv/csi_back.sv =====
module csi_back
  import csi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  job_t          pop_job_i,
  csi_result_if.source  result_o
);

  typedef struct packed {
    logic valid;
    logic has_term;
    logic last;
    logic neg;
  } stage_ctl_t;

  stage_ctl_t         c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [33:0]        mag1_q;
  logic [31:0]        w1_q;
  logic [63:0]        pp_lo2_q;
  logic [33:0]        pp_hi2_q;
  logic [50:0]        n3_q;
  logic [24:0]        a4_q;
  logic [26:0]        ab4_q;
  logic [49:0]        ak5_q;
  logic [25:0]        abq5_q;
  logic signed [63:0] term6_q;
  logic signed [63:0] total_q, total_d;
  logic signed [63:0] integral_q;
  logic               out_valid_q;

  logic               en;
  logic               acc_fire;
  logic signed [34:0] sum_s;
  logic [34:0]        mag_s;
  logic [66:0]        prod_s;
  logic [58:0]        abq_full;
  logic [49:0]        q_s;
  logic [63:0]        q_ext;
  logic signed [63:0] term_s;
  logic signed [63:0] add_s;
  stage_ctl_t         c1_d;

  assign en = !(c6_q.valid && c6_q.last && out_valid_q && !result_o.ready);
  assign pop_ready_o = en;
  assign acc_fire = en && c6_q.valid;

  assign sum_s = 35'(pop_job_i.start_y) + {pop_job_i.middle_y[31], pop_job_i.middle_y, 2'b00}
               + 35'(pop_job_i.end_y);
  assign mag_s = sum_s[34] ? (35'd0 - sum_s) : sum_s;

  always_comb begin
    c1_d.valid    = pop_valid_i;
    c1_d.has_term = pop_valid_i && pop_job_i.has_term;
    c1_d.last     = pop_valid_i && pop_job_i.last;
    c1_d.neg      = pop_valid_i && pop_job_i.has_term && sum_s[34];
  end

  assign prod_s = {3'b000, pp_lo2_q} + {1'b0, pp_hi2_q, 32'd0} + RoundBias;
  assign abq_full = 59'(ab4_q) * 59'(ThirdRecip);
  assign q_s = ak5_q + 50'(abq5_q);
  assign q_ext = 64'(q_s);
  assign term_s = !c5_q.has_term ? 64'sd0 :
                  (c5_q.neg ? $signed(64'd0 - q_ext) : $signed(q_ext));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
      c6_q <= '0;
    end else if (en) begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
      c6_q <= c5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag1_q   <= mag_s[33:0];
      w1_q     <= pop_job_i.step_width;
      pp_lo2_q <= 64'(mag1_q[31:0]) * 64'(w1_q);
      pp_hi2_q <= 34'(mag1_q[33:32]) * 34'(w1_q);
      n3_q     <= prod_s[66:16];
      a4_q     <= n3_q[50:26];
      ab4_q    <= 27'(n3_q[50:26]) + 27'(n3_q[25:0]);
      ak5_q    <= 50'(a4_q) * 50'(ThirdK);
      abq5_q   <= abq_full[58:33];
      term6_q  <= term_s;
    end
  end

  always_comb begin
    add_s = total_q + term6_q;
    total_d = add_s;
    if (!total_q[63] && !term6_q[63] && add_s[63]) begin
      total_d = {1'b0, {63{1'b1}}};
    end else if (total_q[63] && term6_q[63] && !add_s[63]) begin
      total_d = {1'b1, {63{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (acc_fire) begin
        if (c6_q.last) begin
          total_q     <= '0;
          out_valid_q <= 1'b1;
        end else begin
          total_q <= total_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && c6_q.last) begin
      integral_q <= total_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.integral = integral_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_fire && c6_q.last) |=> ((total_q == 64'sd0) && result_o.valid))
    else $error("total not cleared or result not presented after the last sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(c6_q))
    else $error("back pipeline advanced while the result register was blocked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c6_q.valid && !c6_q.has_term) |-> (term6_q == 64'sd0))
    else $error("a job without a closed triple carries a nonzero term");

endmodule

// ===== sv/composite_simpson_integrator.sv =====
// Streaming composite Simpson one-third integrator. Each transaction on sample_i carries one
// (x, y) sample in signed Q16.16; samples 0-1-2, 2-3-4 and so on form triples, each adding
// (y0 + 4*y1 + y2) * |x1 - x0| / 3, rounded to Q16.16, to a saturating Q48.16 total. The
// sample marked last_sample closes the set: the total then leaves as one transaction on
// result_o and the block starts a new set. Sets of fewer than three samples give zero. The
// block takes one sample per cycle while its queue has room; a set's result passes from the
// accepted last sample through a four-entry queue into the first of six back pipeline
// stages of multiply, rounding and divide-by-three steps, on to the last stage, and into the
// result register. Samples stall only when that queue is full, which happens when the result
// register is held by the sink.
module composite_simpson_integrator
  import csi_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  csi_sample_if.sink    sample_i,
  csi_result_if.source  result_o
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  csi_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  csi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  csi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .result_o    (result_o)
  );

endmodule

// ===== dv/simpson_total_check.sv =====
module simpson_total_check
  import csi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  csi_sample_if       sample_i,
  csi_result_if       result_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned integrals_o,
  output int unsigned triples_o,
  output int unsigned clamps_o
);

  localparam logic signed [63:0] TotalMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] TotalMin = 64'sh8000_0000_0000_0000;
  localparam logic [127:0]       HalfThreeUnits = 128'd98304;
  localparam int unsigned        ReportLimit = 10;

  phase_e             phase;
  logic signed [31:0] base_x;
  logic signed [31:0] base_y;
  logic signed [31:0] mid_y;
  logic [31:0]        width;
  logic signed [63:0] total;
  logic signed [63:0] integral_q[$];
  logic signed [32:0] dx;
  logic signed [63:0] term;
  logic [64:0]        wide;
  logic signed [63:0] wanted;

  // Term of one triple: (y0 + 4*y1 + y2) * w / 3, rounded from Q32.32 to Q16.16.
  function automatic logic signed [63:0] simpson_term(logic signed [31:0] y0,
                                                      logic signed [31:0] y1,
                                                      logic signed [31:0] y2,
                                                      logic [31:0] w);
    logic signed [34:0] s;
    logic [34:0]        mag;
    logic [127:0]       prod;
    logic [127:0]       q;
    s = {{3{y0[31]}}, y0} + ({{3{y1[31]}}, y1} << 2) + {{3{y2[31]}}, y2};
    mag = s[34] ? 35'(-s) : 35'(s);
    prod = 128'(mag) * 128'(w) + HalfThreeUnits;
    q = (prod >> 16) / 128'd3;
    return s[34] ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  task automatic clear_set();
    phase = PhaseIdle;
    base_x = '0;
    base_y = '0;
    mid_y = '0;
    width = '0;
    total = '0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_set();
      integral_q.delete();
      mismatches_o = 0;
      pending_o = 0;
      integrals_o = 0;
      triples_o = 0;
      clamps_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        integrals_o++;
        if (integral_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= ReportLimit) begin
            $display("unexpected integral transaction: got %0d", result_i.integral);
          end
        end else begin
          wanted = integral_q.pop_front();
          if (result_i.integral !== wanted) begin
            mismatches_o++;
            if (mismatches_o <= ReportLimit) begin
              $display("integral mismatch: expected %0d, got %0d", wanted, result_i.integral);
            end
          end
        end
      end

      if (sample_i.valid && sample_i.ready) begin
        case (phase)
          PhaseStart: begin
            dx = {sample_i.x_value[31], sample_i.x_value} - {base_x[31], base_x};
            width = dx[32] ? 32'(-dx) : dx[31:0];
            mid_y = sample_i.y_value;
            phase = PhaseMiddle;
          end
          PhaseMiddle: begin
            term = simpson_term(base_y, mid_y, sample_i.y_value, width);
            wide = {total[63], total} + {term[63], term};
            if (wide[64:63] == 2'b01) begin
              total = TotalMax;
              clamps_o++;
            end else if (wide[64:63] == 2'b10) begin
              total = TotalMin;
              clamps_o++;
            end else begin
              total = wide[63:0];
            end
            triples_o++;
            base_x = sample_i.x_value;
            base_y = sample_i.y_value;
            phase = PhaseStart;
          end
          default: begin
            base_x = sample_i.x_value;
            base_y = sample_i.y_value;
            phase = PhaseStart;
          end
        endcase
        if (sample_i.last_sample) begin
          integral_q.push_back(total);
          clear_set();
        end
      end
      pending_o = integral_q.size();
    end
  end

endmodule

// ===== dv/composite_simpson_integrator_test.sv =====
module composite_simpson_integrator_test;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DirectedSamples = 24;
  localparam int unsigned RandomSamples = 1260;
  localparam int unsigned ExtremeTriples = 40;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned IdlePercent = 14;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          steady;
  bit          hold_wanted;
  int unsigned cycles;
  int unsigned samples_sent;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned integral_count;
  int unsigned triple_count;
  int unsigned clamp_count;

  csi_sample_if sample_if();
  csi_result_if result_if();

  composite_simpson_integrator uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .sample_i(sample_if),
    .result_o(result_if)
  );

  simpson_total_check check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_i    (sample_if),
    .result_i    (result_if),
    .mismatches_o(mismatch_count),
    .pending_o   (pending_count),
    .integrals_o (integral_count),
    .triples_o   (triple_count),
    .clamps_o    (clamp_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The result sink stalls at random unless steady is set, and holds off once for long enough to fill the block.
  initial begin
    int unsigned quiet;
    bit          held;
    quiet = 0;
    held = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted && !held) begin
        held = 1'b1;
        quiet = HoldOffCycles;
      end
      if (quiet > 0) begin
        quiet--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= steady || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  task automatic put_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic last);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      sample_if.valid <= 1'b0;
      @(posedge clk);
    end
    sample_if.valid <= 1'b1;
    sample_if.x_value <= x;
    sample_if.y_value <= y;
    sample_if.last_sample <= last;
    do @(posedge clk); while (!sample_if.ready);
    samples_sent++;
  endtask

  task automatic put_set(input int unsigned count);
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] stride;
    bit                 wild;
    wild = ($urandom_range(9) < 4);
    x = $urandom();
    stride = $urandom_range(0, 32'h0003_FFFF);
    if ($urandom_range(7) == 0) begin
      stride = -stride;
    end
    for (int unsigned k = 0; k < count; k++) begin
      if (wild) begin
        x = $urandom();
        y = $urandom();
      end else begin
        y = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      end
      put_sample(x, y, k == count - 1);
      if (!wild) begin
        x = x + stride;
      end
    end
  endtask

  // Widest steps at a constant extreme level, so that every triple carries its largest term.
  task automatic put_extreme_set(input logic signed [31:0] level);
    for (int unsigned k = 0; k <= 2 * ExtremeTriples; k++) begin
      put_sample((k % 2 == 1) ? QMax : QMin, level, k == 2 * ExtremeTriples);
    end
  endtask

  initial begin
    int unsigned len;
    rst_n <= 1'b0;
    sample_if.valid <= 1'b0;
    sample_if.x_value <= '0;
    sample_if.y_value <= '0;
    sample_if.last_sample <= 1'b0;
    steady = 1'b0;
    hold_wanted = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    put_sample(0, QMax, 1'b1);

    put_sample(QMin, QMin, 1'b0);
    put_sample(QMax, QMax, 1'b1);

    put_sample(QMin, QMax, 1'b0);
    put_sample(QMax, QMax, 1'b0);
    put_sample(QMax, QMax, 1'b1);

    put_sample(32'sh0003_0000, -32'sh0001_8000, 1'b0);
    put_sample(32'sh0001_0000, 32'sh0002_0000, 1'b0);
    put_sample(32'sh0005_0000, -1, 1'b0);
    put_sample(QMax, QMin, 1'b1);

    put_sample(QMax, QMin, 1'b0);
    put_sample(QMin, QMin, 1'b0);
    put_sample(0, QMin, 1'b0);
    put_sample(-1, 32'sh0000_1234, 1'b0);
    put_sample(0, QMin, 1'b1);

    put_sample(5, QMax, 1'b0);
    put_sample(5, QMax, 1'b0);
    put_sample(5, QMax, 1'b1);

    put_sample(0, 1, 1'b0);
    put_sample(1, 1, 1'b0);
    put_sample(2, 1, 1'b1);

    put_sample(0, -1, 1'b0);
    put_sample(32'sh0001_0000, -1, 1'b0);
    put_sample(0, -2, 1'b1);

    while (samples_sent < DirectedSamples + RandomSamples) begin
      if (samples_sent > DirectedSamples + 300) begin
        hold_wanted = 1'b1;
      end
      steady = (samples_sent > DirectedSamples + 700 && samples_sent < DirectedSamples + 1000);
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      put_set(len);
    end
    steady = 1'b0;

    put_extreme_set(QMax);
    put_extreme_set(QMin);
    sample_if.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Run covered %0d samples in %0d sets, %0d Simpson triples summed,",
             samples_sent, integral_count, triple_count);
    $display("including %0d clamped additions at the limits of the total.", clamp_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
